### rtl/choc_pkg.sv
package choc_pkg;

   localparam int REF_DEPTH = 256;
   localparam int REF_AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
   localparam int REF_CW    = $clog2(REF_DEPTH + 1);

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_PROBE = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] chunk_hash;
      logic [31:0] chunk_length;
      logic        last_probe;
   } choc_req_type;

   typedef struct packed {
      logic        matched;
      logic [31:0] shared_chunks;
      logic [31:0] matched_len_sum;
      logic [31:0] probed_len_sum;
      logic        set_full;
      logic        is_last;
   } choc_rsp_type;

endpackage

### rtl/chunk_hash_overlap_counter.sv
// Chunk hash overlap counter. An item is taken when start is high and busy is
// low. Clear and load items give no result; a load into a full set is dropped
// and raises set_full. A probe on an empty set gives its result in the cycle
// after acceptance. Any other probe reads the stored hashes from one memory
// with a write and a read port, one entry per cycle, and keeps busy high while
// it scans the N stored hashes (up to 256), stopping at the first equal hash;
// the result appears in the first cycle in which busy is low again. The
// result is shown for exactly one cycle with rsp_valid and must be captured
// then, as the block cannot be stalled; a new item may be started in that same
// cycle.
module chunk_hash_overlap_counter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  choc_pkg::choc_req_type req_item,
   output logic                  rsp_valid,
   output choc_pkg::choc_rsp_type rsp_item
);
   import choc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic [63:0]       ref_mem [REF_DEPTH];
   logic [63:0]       rd_data_ff;
   logic [REF_AW-1:0] rd_addr;

   logic              state_ff, state_in;
   logic [REF_CW-1:0] count_ff, count_in;
   logic [31:0]       chunks_ff, chunks_in;
   logic [31:0]       shared_ff, shared_in;
   logic [31:0]       total_ff, total_in;
   logic              full_ff, full_in;
   logic [REF_AW-1:0] idx_ff, idx_in;
   logic [63:0]       hash_ff, hash_in;
   logic [31:0]       len_ff, len_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   choc_rsp_type      rsp_ff, rsp_in;

   logic              accept;
   logic              mem_we;
   logic              hit;
   logic              scan_end;
   logic              finish;
   logic              finish_hit;
   logic [31:0]       fin_len;
   logic              fin_last;
   logic [REF_CW-1:0] count_m1;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign count_m1 = count_ff - REF_CW'(1);
   assign hit      = (rd_data_ff == hash_ff);
   assign scan_end = (idx_ff == count_m1[REF_AW-1:0]);
   assign mem_we   = accept && (req_item.kind == KIND_LOAD)
                     && (count_ff < REF_CW'(REF_DEPTH));

   always_comb begin
      if (state_ff == ST_SCAN) begin
         rd_addr = idx_ff + REF_AW'(1);
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ref_mem[count_ff[REF_AW-1:0]] <= req_item.chunk_hash;
      end
      rd_data_ff <= ref_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      chunks_in    = chunks_ff;
      shared_in    = shared_ff;
      total_in     = total_ff;
      full_in      = full_ff;
      idx_in       = idx_ff;
      hash_in      = hash_ff;
      len_in       = len_ff;
      last_in      = last_ff;
      finish       = 1'b0;
      finish_hit   = 1'b0;
      fin_len      = len_ff;
      fin_last     = last_ff;

      if (accept) begin
         case (req_item.kind)
            KIND_CLEAR: begin
               count_in  = '0;
               chunks_in = '0;
               shared_in = '0;
               total_in  = '0;
               full_in   = 1'b0;
            end
            KIND_LOAD: begin
               if (count_ff < REF_CW'(REF_DEPTH)) begin
                  count_in = count_ff + REF_CW'(1);
               end else begin
                  full_in = 1'b1;
               end
            end
            KIND_PROBE: begin
               hash_in = req_item.chunk_hash;
               len_in  = req_item.chunk_length;
               last_in = req_item.last_probe;
               if (count_ff == '0) begin
                  // Nothing stored: the probe misses at once.
                  finish   = 1'b1;
                  fin_len  = req_item.chunk_length;
                  fin_last = req_item.last_probe;
               end else begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
            default: begin
            end
         endcase
      end else if (state_ff == ST_SCAN) begin
         // rd_data_ff holds the entry at idx_ff in this cycle.
         if (hit || scan_end) begin
            finish     = 1'b1;
            finish_hit = hit;
            state_in   = ST_IDLE;
         end else begin
            idx_in = idx_ff + REF_AW'(1);
         end
      end

      if (finish) begin
         total_in = total_ff + fin_len;
         if (finish_hit) begin
            chunks_in = chunks_ff + 32'd1;
            shared_in = shared_ff + fin_len;
         end
      end

      rsp_valid_in            = finish;
      rsp_in                  = rsp_ff;
      rsp_in.matched          = finish_hit;
      rsp_in.shared_chunks    = chunks_in;
      rsp_in.matched_len_sum  = shared_in;
      rsp_in.probed_len_sum   = total_in;
      rsp_in.set_full         = full_ff;
      rsp_in.is_last          = fin_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chunks_ff    <= '0;
         shared_ff    <= '0;
         total_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chunks_ff    <= chunks_in;
         shared_ff    <= shared_in;
         total_ff     <= total_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hash_ff <= hash_in;
      len_ff  <= len_in;
      last_ff <= last_in;
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A result is only ever shown while the block is idle, also after a scan.
   a_rsp_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a scan is still running");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= REF_CW'(REF_DEPTH))
      else $error("reference count beyond set depth");

   a_probe_scans : assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.kind == KIND_PROBE) && (count_ff != '0) |=> busy)
      else $error("probe on a non-empty set did not start a scan");

   a_full_load : assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.kind == KIND_LOAD) && (count_ff == REF_CW'(REF_DEPTH))
      |=> full_ff && $stable(count_ff))
      else $error("load into a full set was not dropped");

   a_scan_index : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, idx_ff} < {1'b0, count_ff}))
      else $error("scan index outside the stored entries");

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import choc_pkg::*;

   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int          ITEM_GOAL   = 1650;
   localparam int          QUIET_LIMIT = 4000;
   localparam int          REPORT_MAX  = 10;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   class overlap_scoreboard;
      logic [63:0]  stored_hashes [REF_DEPTH];
      int unsigned  stored_count;
      logic [31:0]  hit_count    = '0;
      logic [31:0]  hit_bytes    = '0;
      logic [31:0]  probe_bytes  = '0;
      logic         dropped_flag = 1'b0;
      choc_rsp_type expected_totals [$];
      int unsigned  failures;
      int unsigned  results_seen;
      int unsigned  probes;
      int unsigned  hits;
      int unsigned  loads;
      int unsigned  clears;
      int unsigned  ignored;
      int unsigned  dropped_loads;
      int unsigned  deepest_set;

      function void flag(string msg);
         failures++;
         if (failures <= REPORT_MAX)
            $display("%0t ns: mismatch: %s", $time, msg);
      endfunction

      // Works out the totals that an accepted item leads to.
      function void update_overlap(choc_req_type it);
         logic         hit;
         choc_rsp_type r;
         case (it.kind)
            KIND_CLEAR: begin
               stored_count = 0;
               hit_count    = '0;
               hit_bytes    = '0;
               probe_bytes  = '0;
               dropped_flag = 1'b0;
               clears++;
            end
            KIND_LOAD: begin
               loads++;
               if (stored_count < REF_DEPTH) begin
                  stored_hashes[stored_count] = it.chunk_hash;
                  stored_count++;
                  if (stored_count > deepest_set)
                     deepest_set = stored_count;
               end else begin
                  dropped_flag = 1'b1;
                  dropped_loads++;
               end
            end
            KIND_PROBE: begin
               hit = 1'b0;
               for (int i = 0; i < stored_count; i++)
                  if (stored_hashes[i] == it.chunk_hash)
                     hit = 1'b1;
               probe_bytes = probe_bytes + it.chunk_length;
               if (hit) begin
                  hit_count = hit_count + 32'd1;
                  hit_bytes = hit_bytes + it.chunk_length;
                  hits++;
               end
               r.matched         = hit;
               r.shared_chunks   = hit_count;
               r.matched_len_sum = hit_bytes;
               r.probed_len_sum  = probe_bytes;
               r.set_full        = dropped_flag;
               r.is_last         = it.last_probe;
               expected_totals.push_back(r);
               probes++;
            end
            default: begin
               ignored++;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want)
            flag($sformatf("%s expected %0h, got %0h", name, want, got));
      endfunction

      function void check_totals(choc_rsp_type got);
         choc_rsp_type want;
         results_seen++;
         if (expected_totals.size() == 0) begin
            flag($sformatf("result with nothing outstanding: %p", got));
            return;
         end
         want = expected_totals.pop_front();
         compare_field("matched", want.matched, got.matched);
         compare_field("shared_chunks", want.shared_chunks, got.shared_chunks);
         compare_field("matched_len_sum", want.matched_len_sum, got.matched_len_sum);
         compare_field("probed_len_sum", want.probed_len_sum, got.probed_len_sum);
         compare_field("set_full", want.set_full, got.set_full);
         compare_field("is_last", want.is_last, got.is_last);
      endfunction

      function int unsigned waiting();
         return expected_totals.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   choc_req_type req_item;
   logic         rsp_valid;
   choc_rsp_type rsp_item;

   overlap_scoreboard board = new;
   int unsigned       quiet_cycles;
   int unsigned       sent;
   bit                idling_on;
   logic [63:0]       loaded_hashes [$];

   chunk_hash_overlap_counter dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Results are checked before the new item is noted, since a result and
   // the acceptance of the next item may share an edge.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid)
            board.check_totals(rsp_item);
         if (start && !busy)
            board.update_overlap(req_item);
         quiet_cycles <= (rsp_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send(input logic [1:0] kind, input logic [63:0] hash,
                       input logic [31:0] len, input logic last);
      choc_req_type it;
      it.kind         = kind;
      it.chunk_hash   = hash;
      it.chunk_length = len;
      it.last_probe   = last;
      if (idling_on && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      if (kind != KIND_UNUSED)
         sent++;
      if (kind == KIND_CLEAR)
         loaded_hashes.delete();
      else if (kind == KIND_LOAD)
         loaded_hashes.push_back(hash);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (board.waiting() != 0)
         @(posedge clock);
   endtask

   task automatic send_probe(input bit want_hit, input logic last);
      logic [63:0] hash;
      logic [31:0] len;
      int unsigned roll;
      if (want_hit && loaded_hashes.size() > 0)
         hash = loaded_hashes[$urandom_range(loaded_hashes.size() - 1)];
      else
         hash = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 8)
         len = '0;
      else if (roll < 16)
         len = '1;
      else if (roll < 50)
         len = $urandom_range(16384);
      else
         len = $urandom;
      send(KIND_PROBE, hash, len, last);
   endtask

   initial begin
      int unsigned roll;
      int unsigned fill;
      int unsigned burst;
      logic [63:0] hash;
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      sent      = 0;
      idling_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty set, duplicates, wrapping sums, near misses, the
      // unused kind and a clear of a filled set.
      send(KIND_CLEAR, ALL_ONES, 32'hFFFF_FFFF, 1'b1);
      send(KIND_PROBE, ALL_ONES, 32'hFFFF_FFFF, 1'b0);
      send(KIND_PROBE, 64'h0, 32'h0, 1'b1);
      send(KIND_UNUSED, 64'h0, 32'd5, 1'b1);
      send(KIND_LOAD, 64'h0, 32'hFFFF_FFFF, 1'b1);
      send(KIND_LOAD, ALL_ONES, 32'h0, 1'b0);
      send(KIND_LOAD, 64'h0, 32'h1, 1'b0);
      send(KIND_LOAD, 64'h8000_0000_0000_0001, 32'h0, 1'b0);
      send(KIND_PROBE, 64'h0, 32'hFFFF_FFFF, 1'b0);
      send(KIND_PROBE, ALL_ONES, 32'h1, 1'b0);
      send(KIND_PROBE, 64'h8000_0000_0000_0000, 32'h1234_5678, 1'b0);
      send(KIND_PROBE, 64'h0000_0000_0000_0001, 32'h8000_0000, 1'b0);
      send(KIND_PROBE, 64'h8000_0000_0000_0001, 32'h0, 1'b1);
      send(KIND_UNUSED, ALL_ONES, 32'hFFFF_FFFF, 1'b0);
      send(KIND_CLEAR, 64'h0, 32'h0, 1'b0);
      send(KIND_PROBE, 64'h0, 32'd7, 1'b1);
      drain_results();

      // Random: mostly a clear, a reference set and a burst of probes,
      // with the odd stray item mixed in.
      while (sent < ITEM_GOAL) begin
         idling_on = !(sent >= 700 && sent < 1100);
         if ($urandom_range(99) < 80)
            send(KIND_CLEAR, {$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
         roll = $urandom_range(99);
         if (roll < 6)
            fill = REF_DEPTH + $urandom_range(4, 1);
         else if (roll < 12)
            fill = 0;
         else if (roll < 22)
            fill = $urandom_range(64, 17);
         else
            fill = $urandom_range(16, 1);
         for (int i = 0; i < fill; i++) begin
            if (loaded_hashes.size() > 0 && $urandom_range(9) == 0)
               hash = loaded_hashes[$urandom_range(loaded_hashes.size() - 1)];
            else
               hash = {$urandom, $urandom};
            send(KIND_LOAD, hash, $urandom, 1'($urandom_range(1)));
         end
         burst = $urandom_range(24, 2);
         for (int j = 0; j < burst; j++) begin
            roll = $urandom_range(99);
            if (roll < 4)
               send(KIND_UNUSED, {$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
            else if (roll < 8)
               send(KIND_LOAD, {$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
            else if (roll < 10)
               send(KIND_CLEAR, {$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
            send_probe($urandom_range(99) < 60,
                       (j == burst - 1) || ($urandom_range(19) == 0));
         end
         if ($urandom_range(9) < 2)
            drain_results();
      end

      start <= 1'b0;
      @(posedge clock);
      while (board.waiting() != 0)
         @(posedge clock);
      repeat (REF_DEPTH + 40) @(posedge clock);

      $display("covered %0d probes (%0d hits), %0d loads (%0d dropped), %0d clears,",
               board.probes, board.hits, board.loads, board.dropped_loads, board.clears);
      $display("%0d ignored items; largest set %0d hashes; %0d results, %0d failures",
               board.ignored, board.deepest_set, board.results_seen, board.failures);
      if (board.failures == 0 && board.waiting() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
